### rtl/ptm_pkg.sv
// Types and constants shared by the periodic task timing monitor.
package ptm_pkg;

    typedef enum logic [1:0] {
        REQ_QUERY        = 2'd0,
        REQ_EXEC_START   = 2'd1,
        REQ_EXEC_END     = 2'd2,
        REQ_START_TIMING = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        REG_EARLY_MARGIN = 2'd0,
        REG_LATE_MARGIN  = 2'd1,
        REG_TASK_PERIOD  = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    localparam logic [15:0] EARLY_MARGIN_RST = 16'd75;
    localparam logic [15:0] LATE_MARGIN_RST  = 16'd50;
    localparam logic [15:0] TASK_PERIOD_RST  = 16'd100;

    localparam logic [15:0]        RUN_MIN_RST  = 16'hFFFF;
    localparam logic signed [15:0] ACC_MIN_RST  = 16'sh7FFF;
    localparam logic signed [15:0] ACC_MAX_RST  = 16'sh8000;
    localparam logic [31:0]        DEADLINE_RST = 32'hFFFF_FFFF;
    localparam logic [31:0]        DEADLINE_NOW = 32'h0000_0000;
    localparam logic [15:0]        AVAIL_UNLIM  = 16'hFFFF;
    localparam logic [15:0]        AVAIL_MAX    = 16'h7FFF;

    typedef struct packed {
        req_kind_t          req_type;
        logic signed [31:0] time_value;
        logic [2:0]         retrigger_mask;
        logic signed [31:0] exec_deadline;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] time_to_trigger;
        logic signed [15:0] available_time;
        logic [15:0]        last_exec_time;
        logic [15:0]        min_exec_time;
        logic [15:0]        max_exec_time;
        logic [31:0]        run_count;
        logic [31:0]        exec_time_sum;
        logic signed [31:0] accuracy_sum;
        logic signed [15:0] min_accuracy;
        logic signed [15:0] max_accuracy;
    } rsp_word_t;

endpackage

### rtl/periodic_task_timing_monitor.sv
// Periodic task timing monitor: trigger window queries and run time statistics.
//
// Each request word is registered, evaluated combinationally and its response word
// registered, so the monitor takes one word per clock; a stalled response holds the
// input register, and there is no other limit on throughput. Every request returns
// one response carrying the statistics after that request. Margins and period are
// written over the APB port at byte offsets 0x0, 0x4 and 0x8 (low 16 bits used); the
// user must write them only while no request is in flight, which the block itself
// does not enforce.
module periodic_task_timing_monitor
    import ptm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  req_word_t   req,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_word_t   rsp,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] early_margin_reg;
    logic [15:0] late_margin_reg;
    logic [15:0] task_period_reg;

    logic        in_valid_reg;
    req_word_t   in_word_reg;
    logic        rsp_valid_reg;
    rsp_word_t   rsp_word_reg;

    logic [31:0]        next_trigger_reg,   next_trigger_next;
    logic [31:0]        run_start_reg,      run_start_next;
    logic [31:0]        deadline_reg,       deadline_next;
    logic [15:0]        last_run_reg,       last_run_next;
    logic [15:0]        shortest_run_reg,   shortest_run_next;
    logic [15:0]        longest_run_reg,    longest_run_next;
    logic [31:0]        count_runs_reg,     count_runs_next;
    logic [31:0]        total_run_reg,      total_run_next;
    logic [31:0]        total_accuracy_reg, total_accuracy_next;
    logic signed [15:0] lowest_acc_reg,     lowest_acc_next;
    logic signed [15:0] highest_acc_reg,    highest_acc_next;

    logic        advance;
    logic        cfg_write;
    reg_index_t  cfg_index;

    logic [31:0] now;
    logic [31:0] win_early;
    logic [31:0] win_nominal;
    logic [31:0] win_late;
    logic [31:0] ttt;
    logic [31:0] prev_win;
    logic        done;
    logic [15:0] avail;
    logic [31:0] dl_diff;
    logic [31:0] delta;
    logic signed [15:0] delta_sat;
    rsp_word_t   rsp_word_next;

    // ---- handshake ----
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // ---- configuration ----
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_index)
            REG_EARLY_MARGIN: prdata = {16'd0, early_margin_reg};
            REG_LATE_MARGIN:  prdata = {16'd0, late_margin_reg};
            REG_TASK_PERIOD:  prdata = {16'd0, task_period_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early_margin_reg <= EARLY_MARGIN_RST;
            late_margin_reg  <= LATE_MARGIN_RST;
            task_period_reg  <= TASK_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EARLY_MARGIN: early_margin_reg <= pwdata[15:0];
                REG_LATE_MARGIN:  late_margin_reg  <= pwdata[15:0];
                REG_TASK_PERIOD:  task_period_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // ---- query: trigger windows ----
    assign now         = in_word_reg.time_value;
    assign win_early   = next_trigger_reg - {16'd0, early_margin_reg} - now;
    assign win_nominal = next_trigger_reg - now;
    assign win_late    = next_trigger_reg + {16'd0, late_margin_reg} - now;

    always_comb
    begin
        ttt      = 32'd0;
        prev_win = 32'd0;
        done     = 1'b0;
        if (in_word_reg.retrigger_mask[0])
        begin
            ttt      = win_early;
            prev_win = win_early;
            done     = !win_early[31];
        end
        if (!done && in_word_reg.retrigger_mask[1])
        begin
            if (prev_win[31] && !win_nominal[31] && (win_nominal != 32'd0))
            begin
                ttt  = 32'd0;
                done = 1'b1;
            end
            else
            begin
                ttt      = win_nominal;
                done     = !win_nominal[31];
                prev_win = win_nominal;
            end
        end
        if (!done && in_word_reg.retrigger_mask[2])
        begin
            if (prev_win[31] && !win_late[31] && (win_late != 32'd0))
                ttt = 32'd0;
            else
                ttt = win_late;
        end
    end

    // ---- query: time left before deadline ----
    assign dl_diff = deadline_reg - now;

    always_comb
    begin
        if (deadline_reg == DEADLINE_NOW)
            avail = 16'd0;
        else if (deadline_reg == DEADLINE_RST)
            avail = AVAIL_UNLIM;
        else if ($signed(now) >= $signed(deadline_reg))
            avail = 16'd0;
        else if (dl_diff > {16'd0, AVAIL_MAX})
            avail = AVAIL_MAX;
        else
            avail = dl_diff[15:0];
    end

    // ---- accuracy delta, saturated ----
    assign delta = next_trigger_reg - run_start_reg;

    always_comb
    begin
        if (!delta[31] && (delta[30:15] != 16'd0))
            delta_sat = ACC_MIN_RST;
        else if (delta[31] && (delta[30:15] != 16'hFFFF))
            delta_sat = ACC_MAX_RST;
        else
            delta_sat = delta[15:0];
    end

    // ---- state update ----
    always_comb
    begin
        next_trigger_next   = next_trigger_reg;
        run_start_next      = run_start_reg;
        deadline_next       = deadline_reg;
        last_run_next       = last_run_reg;
        shortest_run_next   = shortest_run_reg;
        longest_run_next    = longest_run_reg;
        count_runs_next     = count_runs_reg;
        total_run_next      = total_run_reg;
        total_accuracy_next = total_accuracy_reg;
        lowest_acc_next     = lowest_acc_reg;
        highest_acc_next    = highest_acc_reg;

        case (in_word_reg.req_type)
            REQ_QUERY:        ;
            REQ_EXEC_START:
            begin
                run_start_next = now;
                deadline_next  = in_word_reg.exec_deadline;
            end
            REQ_EXEC_END:
            begin
                last_run_next   = now[15:0] - run_start_reg[15:0];
                count_runs_next = count_runs_reg + 32'd1;
                if (count_runs_next != 32'd0)
                begin
                    total_run_next      = total_run_reg + {16'd0, last_run_next};
                    total_accuracy_next = total_accuracy_reg + delta;
                    if (last_run_next > longest_run_reg)
                        longest_run_next = last_run_next;
                    if (last_run_next < shortest_run_reg)
                        shortest_run_next = last_run_next;
                    if (delta_sat > highest_acc_reg)
                        highest_acc_next = delta_sat;
                    if (delta_sat < lowest_acc_reg)
                        lowest_acc_next = delta_sat;
                end
                else
                begin
                    total_run_next      = 32'd0;
                    total_accuracy_next = 32'd0;
                    longest_run_next    = 16'd0;
                    shortest_run_next   = RUN_MIN_RST;
                    lowest_acc_next     = ACC_MIN_RST;
                    highest_acc_next    = ACC_MAX_RST;
                end
                next_trigger_next = next_trigger_reg + {16'd0, task_period_reg};
            end
            REQ_START_TIMING: next_trigger_next = now;
            default:          ;
        endcase
    end

    // ---- response word ----
    always_comb
    begin
        rsp_word_next.time_to_trigger = 32'sd0;
        rsp_word_next.available_time  = 16'sd0;
        if (in_word_reg.req_type == REQ_QUERY)
        begin
            rsp_word_next.time_to_trigger = ttt;
            rsp_word_next.available_time  = avail;
        end
        rsp_word_next.last_exec_time = last_run_next;
        rsp_word_next.min_exec_time  = shortest_run_next;
        rsp_word_next.max_exec_time  = longest_run_next;
        rsp_word_next.run_count      = count_runs_next;
        rsp_word_next.exec_time_sum  = total_run_next;
        rsp_word_next.accuracy_sum   = total_accuracy_next;
        rsp_word_next.min_accuracy   = lowest_acc_next;
        rsp_word_next.max_accuracy   = highest_acc_next;
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            next_trigger_reg   <= 32'd0;
            run_start_reg      <= 32'd0;
            deadline_reg       <= DEADLINE_RST;
            last_run_reg       <= 16'd0;
            shortest_run_reg   <= RUN_MIN_RST;
            longest_run_reg    <= 16'd0;
            count_runs_reg     <= 32'd0;
            total_run_reg      <= 32'd0;
            total_accuracy_reg <= 32'd0;
            lowest_acc_reg     <= ACC_MIN_RST;
            highest_acc_reg    <= ACC_MAX_RST;
        end
        else
        begin
            if (!req_stall)
                in_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (advance)
            begin
                next_trigger_reg   <= next_trigger_next;
                run_start_reg      <= run_start_next;
                deadline_reg       <= deadline_next;
                last_run_reg       <= last_run_next;
                shortest_run_reg   <= shortest_run_next;
                longest_run_reg    <= longest_run_next;
                count_runs_reg     <= count_runs_next;
                total_run_reg      <= total_run_next;
                total_accuracy_reg <= total_accuracy_next;
                lowest_acc_reg     <= lowest_acc_next;
                highest_acc_reg    <= highest_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_word_reg <= req;
        if (advance)
            rsp_word_reg <= rsp_word_next;
    end

endmodule

### bench/tb.sv
// Testbench for the periodic task timing monitor: random and directed requests checked per field.
`timescale 1ns / 100ps

module tb;
    import ptm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 280;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_word_t   req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_word_t   rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the block's registers and state
    logic [15:0]        cfg_early, cfg_late, cfg_period;
    logic [31:0]        trig_next, run_begin, run_deadline, runs_done, run_total, acc_total;
    logic [15:0]        run_last, run_min, run_max;
    logic signed [15:0] acc_min, acc_max;

    req_word_t req_backlog[$];
    rsp_word_t rsp_expected[$];
    rsp_word_t rsp_want;

    int errors = 0;
    int gap_left, stall_left, hold_left, rx_count, quiet;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    logic [31:0] gen_now, gen_trig;

    periodic_task_timing_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rsp_word_t track_request(req_word_t r);
        rsp_word_t          o;
        logic [31:0]        now, res, prev, dlt;
        logic signed [15:0] d16;
        bit                 done;
        o = '0;
        now = r.time_value;
        case (r.req_type)
            REQ_QUERY:
            begin
                prev = '0;
                res  = '0;
                done = 1'b0;
                if (r.retrigger_mask[0])
                begin
                    res  = trig_next - {16'd0, cfg_early} - now;
                    prev = res;
                    done = !res[31];
                end
                if (!done && r.retrigger_mask[1])
                begin
                    res = trig_next - now;
                    if (prev[31] && res != 0 && !res[31])
                    begin
                        res  = '0;
                        done = 1'b1;
                    end
                    else if (!res[31])
                        done = 1'b1;
                    else
                        prev = res;
                end
                if (!done && r.retrigger_mask[2])
                begin
                    res = trig_next + {16'd0, cfg_late} - now;
                    if (prev[31] && res != 0 && !res[31])
                        res = '0;
                end
                o.time_to_trigger = res;
                if (run_deadline == DEADLINE_NOW)
                    o.available_time = '0;
                else if (run_deadline == DEADLINE_RST)
                    o.available_time = AVAIL_UNLIM;
                else if ($signed(now) >= $signed(run_deadline))
                    o.available_time = '0;
                else
                begin
                    dlt = run_deadline - now;
                    o.available_time = (dlt > 32'd32767) ? AVAIL_MAX : dlt[15:0];
                end
            end
            REQ_EXEC_START:
            begin
                run_begin    = now;
                run_deadline = r.exec_deadline;
            end
            REQ_EXEC_END:
            begin
                dlt = now - run_begin;
                run_last = dlt[15:0];
                runs_done = runs_done + 32'd1;
                if (runs_done != 0)
                begin
                    dlt = trig_next - run_begin;
                    if ($signed(dlt) > 32767)
                        d16 = 16'sh7FFF;
                    else if ($signed(dlt) < -32768)
                        d16 = 16'sh8000;
                    else
                        d16 = dlt[15:0];
                    run_total = run_total + {16'd0, run_last};
                    if (run_last > run_max)
                        run_max = run_last;
                    if (run_last < run_min)
                        run_min = run_last;
                    acc_total = acc_total + dlt;
                    if (d16 > acc_max)
                        acc_max = d16;
                    if (d16 < acc_min)
                        acc_min = d16;
                end
                else
                begin
                    run_total = '0;
                    run_max   = '0;
                    run_min   = RUN_MIN_RST;
                    acc_total = '0;
                    acc_max   = ACC_MAX_RST;
                    acc_min   = ACC_MIN_RST;
                end
                trig_next = trig_next + {16'd0, cfg_period};
            end
            REQ_START_TIMING:
                trig_next = now;
            default: ;
        endcase
        o.last_exec_time = run_last;
        o.min_exec_time  = run_min;
        o.max_exec_time  = run_max;
        o.run_count      = runs_done;
        o.exec_time_sum  = run_total;
        o.accuracy_sum   = acc_total;
        o.min_accuracy   = acc_min;
        o.max_accuracy   = acc_max;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic push_req(req_kind_t k, logic [31:0] t, logic [2:0] m, logic [31:0] dl);
        req_word_t w;
        w.req_type       = k;
        w.time_value     = t;
        w.retrigger_mask = m;
        w.exec_deadline  = dl;
        req_backlog.push_back(w);
    endtask

    task automatic apb_access(input bit wr, input reg_index_t idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_reg(reg_index_t idx, logic [15:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, {16'($urandom), val}, rd);
        case (idx)
            REG_EARLY_MARGIN: cfg_early  = val;
            REG_LATE_MARGIN:  cfg_late   = val;
            REG_TASK_PERIOD:  cfg_period = val;
            default: ;
        endcase
        if (idx != REG_NONE)
        begin
            apb_access(1'b0, idx, 32'd0, rd);
            check_field("register readback", rd[15:0], val);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || rsp_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // one well-formed run: optional retime, queries, exec start, queries, exec end
    task automatic add_run();
        int          span;
        logic [31:0] s, dl;
        if ($urandom_range(0, 7) == 0)
        begin
            gen_trig = gen_now + $urandom_range(0, 300);
            push_req(REQ_START_TIMING, gen_trig, 3'($urandom_range(0, 7)), $urandom);
        end
        span = cfg_early + cfg_late + 40;
        repeat ($urandom_range(0, 3))
            push_req(REQ_QUERY, gen_trig - cfg_early - 20 + $urandom_range(0, span),
                     3'($urandom_range(0, 7)), $urandom);
        s = gen_trig - cfg_early - 20 + $urandom_range(0, span);
        case ($urandom_range(0, 5))
            0:       dl = DEADLINE_RST;
            1:       dl = DEADLINE_NOW;
            2:       dl = s + $urandom_range(1, 400);
            3:       dl = s + $urandom_range(30000, 200000);
            4:       dl = s - $urandom_range(0, 100);
            default: dl = $urandom;
        endcase
        push_req(REQ_EXEC_START, s, 3'($urandom_range(0, 7)), dl);
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000) : $urandom_range(0, 300);
        repeat ($urandom_range(0, 2))
            push_req(REQ_QUERY, s + $urandom_range(0, span), 3'($urandom_range(0, 7)),
                     $urandom);
        gen_now = s + span;
        push_req(REQ_EXEC_END, gen_now, 3'($urandom_range(0, 7)), $urandom);
        gen_trig = gen_trig + cfg_period;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                rsp_expected.push_back(track_request(req));
                gap_left = gaps_on ? $urandom_range(0, 5) : 0;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req       <= req_backlog.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            rx_count   = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    rsp_want = rsp_expected.pop_front();
                    check_field("time_to_trigger", rsp.time_to_trigger, rsp_want.time_to_trigger);
                    check_field("available_time", rsp.available_time, rsp_want.available_time);
                    check_field("last_exec_time", rsp.last_exec_time, rsp_want.last_exec_time);
                    check_field("min_exec_time", rsp.min_exec_time, rsp_want.min_exec_time);
                    check_field("max_exec_time", rsp.max_exec_time, rsp_want.max_exec_time);
                    check_field("run_count", rsp.run_count, rsp_want.run_count);
                    check_field("exec_time_sum", rsp.exec_time_sum, rsp_want.exec_time_sum);
                    check_field("accuracy_sum", rsp.accuracy_sum, rsp_want.accuracy_sum);
                    check_field("min_accuracy", rsp.min_accuracy, rsp_want.min_accuracy);
                    check_field("max_accuracy", rsp.max_accuracy, rsp_want.max_accuracy);
                end
                rx_count++;
                // long hold-off so the request side backs up
                if (rx_count % 900 == 300)
                    hold_left = 80;
                stall_left = stalls_on ? $urandom_range(0, 5) : 0;
            end
            else
            begin
                if (stall_left > 0)
                    stall_left--;
                if (hold_left > 0)
                    hold_left--;
            end
            rsp_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, %0d words outstanding", $time, rsp_expected.size());
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        cfg_early    = EARLY_MARGIN_RST;
        cfg_late     = LATE_MARGIN_RST;
        cfg_period   = TASK_PERIOD_RST;
        trig_next    = '0;
        run_begin    = '0;
        run_deadline = DEADLINE_RST;
        run_last     = '0;
        run_min      = RUN_MIN_RST;
        run_max      = '0;
        runs_done    = '0;
        run_total    = '0;
        acc_total    = '0;
        acc_min      = ACC_MIN_RST;
        acc_max      = ACC_MAX_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: window rule, deadline cases, accuracy saturation, run time wrap
        @(negedge clk);
        push_req(REQ_QUERY, 32'd0, 3'b000, 32'd0);
        push_req(REQ_START_TIMING, 32'd1000, 3'b111, 32'hFFFF_FFFF);
        push_req(REQ_QUERY, 32'd900, 3'b001, 32'd0);
        push_req(REQ_QUERY, 32'd950, 3'b011, 32'd0);
        push_req(REQ_QUERY, 32'd950, 3'b010, 32'd0);
        push_req(REQ_QUERY, 32'd1040, 3'b111, 32'd0);
        push_req(REQ_QUERY, 32'd1040, 3'b101, 32'd0);
        push_req(REQ_QUERY, 32'd1100, 3'b111, 32'd0);
        push_req(REQ_QUERY, 32'd1100, 3'b100, 32'd0);
        push_req(REQ_QUERY, 32'h7FFF_FFFF, 3'b110, 32'h7FFF_FFFF);
        push_req(REQ_QUERY, 32'h8000_0000, 3'b101, 32'h8000_0000);
        push_req(REQ_EXEC_START, 32'd1010, 3'b000, DEADLINE_NOW);
        push_req(REQ_QUERY, 32'd1015, 3'b111, 32'd0);
        push_req(REQ_EXEC_START, 32'd1010, 3'b111, DEADLINE_RST);
        push_req(REQ_QUERY, 32'd1015, 3'b111, 32'd0);
        push_req(REQ_EXEC_START, 32'd1010, 3'b000, 32'd101010);
        push_req(REQ_QUERY, 32'd1020, 3'b010, 32'd0);
        push_req(REQ_EXEC_START, 32'd1010, 3'b000, 32'd1060);
        push_req(REQ_QUERY, 32'd1020, 3'b010, 32'd0);
        push_req(REQ_QUERY, 32'd1060, 3'b010, 32'd0);
        push_req(REQ_EXEC_END, 32'd1030, 3'b000, 32'd0);
        push_req(REQ_EXEC_START, 32'd101100, 3'b000, 32'h7FFF_FFFF);
        push_req(REQ_EXEC_END, 32'd171100, 3'b000, 32'd0);
        push_req(REQ_EXEC_START, -32'sd98800, 3'b000, 32'h8000_0000);
        push_req(REQ_QUERY, -32'sd98800, 3'b111, 32'd0);
        push_req(REQ_EXEC_END, -32'sd98790, 3'b111, 32'hFFFF_FFFF);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    set_reg(REG_EARLY_MARGIN, 16'd0);
                    set_reg(REG_LATE_MARGIN, 16'd0);
                    set_reg(REG_TASK_PERIOD, 16'd0);
                    set_reg(REG_NONE, 16'hFFFF);
                end
                1:
                begin
                    set_reg(REG_EARLY_MARGIN, 16'hFFFF);
                    set_reg(REG_LATE_MARGIN, 16'hFFFF);
                    set_reg(REG_TASK_PERIOD, 16'hFFFF);
                end
                3:
                begin
                    set_reg(REG_EARLY_MARGIN, EARLY_MARGIN_RST);
                    set_reg(REG_LATE_MARGIN, LATE_MARGIN_RST);
                    set_reg(REG_TASK_PERIOD, TASK_PERIOD_RST);
                end
                4:
                begin
                    set_reg(REG_EARLY_MARGIN, 16'($urandom));
                    set_reg(REG_LATE_MARGIN, 16'($urandom));
                    set_reg(REG_TASK_PERIOD, 16'($urandom));
                end
                default:
                begin
                    set_reg(REG_EARLY_MARGIN, 16'($urandom_range(0, 300)));
                    set_reg(REG_LATE_MARGIN, 16'($urandom_range(0, 300)));
                    set_reg(REG_TASK_PERIOD, 16'($urandom_range(0, 300)));
                end
            endcase
            gaps_on   = (ph % 3 != 1);
            stalls_on = (ph % 3 != 1);
            @(negedge clk);
            gen_now  = $urandom;
            gen_trig = gen_now + 100;
            push_req(REQ_START_TIMING, gen_trig, 3'($urandom_range(0, 7)), $urandom);
            while (req_backlog.size() < PHASE_WORDS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    push_req(req_kind_t'($urandom_range(0, 3)), $urandom,
                             3'($urandom_range(0, 7)), $urandom);
                    if (req_backlog[$].req_type == REQ_START_TIMING)
                        gen_trig = req_backlog[$].time_value;
                end
                else
                    add_run();
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
